/* hdl/flow_batch_monitor_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for flow_batch_monitor_core
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FLOW_BATCH_MONITOR_CORE_ASSERT_SVH
`define FLOW_BATCH_MONITOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check prop at every rising edge of clk, off while rst is high
`define FBM_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check prop at every rising edge of clk, reset included
`define FBM_ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBM_ASSERT_RST(label, clk, rst, prop, msg)
`define FBM_ASSERT_ALL(label, clk, prop, msg)
`endif

`endif

/* hdl/fbm_pkg.sv */
// ----------------------------------------------------------------------------
// fbm_pkg
// Shared types and constants of the batch flow monitor.
// ----------------------------------------------------------------------------
package fbm_pkg;

  // internal count arithmetic width (wraps modulo 2^CNT_W)
  localparam int unsigned CNT_W = 32;

  localparam logic [15:0] THRESH_RESET  = 16'd150;
  localparam logic [7:0]  CMD_RESET     = 8'h80;
  localparam int unsigned REARM_BIT     = 5;
  localparam logic [7:0]  STATUS_ALWAYS = 8'h80;
  localparam logic [7:0]  STATUS_RUN    = 8'h30;

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_MEASURE = 2'd1,
    OP_COMMAND = 2'd2,
    OP_BUTTON  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] encoder_count;
    logic [7:0]         command_value;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic [7:0]         status_byte;
    logic signed [31:0] measured_count;
    logic               valve_open;
    logic               flow_indicator;
  } result_t;

endpackage

/* hdl/flow_batch_monitor_core.sv */
// ----------------------------------------------------------------------------
// flow_batch_monitor_core
// Batch flow monitor on encoder counts: start on flow, report, stop, rearm.
// ----------------------------------------------------------------------------
//   channel   signals                                  handshake
//   in        op, encoder_count, command_value         in_valid / in_ready
//   out       phase, status_byte, measured_count,      out_valid / out_ready
//             valve_open, flow_indicator
//   cfg       cfg_wdata (flow_threshold)               cfg_we, no wait
//
// One word per cycle sustained while the output is taken; a result passes the input
// register, then one update pass into the result register, and can then be taken
// from the output.
// The update pass is two subtracts and two compares on the count width.
// A stalled output holds the result register and then the input register.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module flow_batch_monitor_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [31:0] encoder_count,
  input  logic [7:0]         command_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         phase,
  output logic [7:0]         status_byte,
  output logic signed [31:0] measured_count,
  output logic               valve_open,
  output logic               flow_indicator,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import fbm_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    take;
  result_t upd_result;
  result_t out_data;

  assign in_item.op            = op_t'(op);
  assign in_item.encoder_count = encoder_count;
  assign in_item.command_value = command_value;

  // held word moves on when the result register is free or draining
  assign take = held_valid && (!out_valid || out_ready);

  fbm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  fbm_update u_upd (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (held_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (upd_result)
  );

  fbm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_data (upd_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign phase          = out_data.phase;
  assign status_byte    = out_data.status_byte;
  assign measured_count = out_data.measured_count;
  assign valve_open     = out_data.valve_open;
  assign flow_indicator = out_data.flow_indicator;

endmodule

/* hdl/fbm_in_stage.sv */
// ----------------------------------------------------------------------------
// fbm_in_stage
// Input register: holds one accepted word until the update stage takes it.
// ----------------------------------------------------------------------------
module fbm_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fbm_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output fbm_pkg::item_t held_item
);
  import fbm_pkg::*;

  logic  held_valid_next;
  item_t held_q;

  // free slot, or the held word leaves this cycle
  assign in_ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_q <= in_item;
    end
  end

  assign held_item = held_q;

endmodule

/* hdl/fbm_update.sv */
// ----------------------------------------------------------------------------
// fbm_update
// Monitor state and its single-pass next-state logic; threshold register.
// ----------------------------------------------------------------------------
module fbm_update (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  fbm_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata,
  output fbm_pkg::result_t result
);
  import fbm_pkg::*;

  `include "flow_batch_monitor_core_assert.svh"

  // state
  logic [15:0] flow_threshold;
  phase_t      phase;
  logic        flow_seen;
  cnt_t        previous_sample;
  cnt_t        batch_base;
  cnt_t        reported_count;
  logic [7:0]  command_byte;
  logic        valve_toggle;
  logic        valve_drive;
  logic        button_pending;

  // next values
  phase_t      phase_next;
  logic        flow_seen_next;
  cnt_t        previous_sample_next;
  cnt_t        batch_base_next;
  cnt_t        reported_count_next;
  logic [7:0]  command_byte_next;
  logic        valve_toggle_next;
  logic        valve_drive_next;
  logic        button_pending_next;

  cnt_t        count;
  cnt_t        base_sample;
  cnt_t        gain;
  cnt_t        rel;
  logic        rearm_req;

  // sign-extend the sampled count into the working width
  assign count = cnt_t'(item.encoder_count);

  always_comb begin
    phase_next           = phase;
    flow_seen_next       = flow_seen;
    previous_sample_next = previous_sample;
    batch_base_next      = batch_base;
    reported_count_next  = reported_count;
    command_byte_next    = command_byte;
    valve_toggle_next    = valve_toggle;
    valve_drive_next     = valve_drive;
    button_pending_next  = button_pending;
    rearm_req            = 1'b0;

    // negative sample resyncs the reference, gain then zero
    base_sample = count[CNT_W-1] ? count : previous_sample;
    gain        = count - base_sample;
    rel         = count - batch_base;

    case (item.op)
      OP_CHECK: begin
        if (phase == PH_WAIT) begin
          if (!gain[CNT_W-1] && (gain >= cnt_t'(flow_threshold))) begin
            flow_seen_next  = 1'b1;
            batch_base_next = base_sample;
            phase_next      = PH_RUN;
          end else begin
            flow_seen_next = 1'b0;
          end
          previous_sample_next = count;
        end
      end
      OP_MEASURE: begin
        if (phase == PH_RUN) begin
          reported_count_next = rel;
          if (rel == previous_sample) begin
            // flow stalled: stop, close valve
            phase_next       = PH_STOP;
            valve_drive_next = 1'b0;
            rearm_req        = 1'b1;
          end else begin
            previous_sample_next = rel;
          end
        end
      end
      OP_COMMAND: begin
        command_byte_next = item.command_value;
        rearm_req         = (phase == PH_STOP);
      end
      OP_BUTTON: begin
        if (phase == PH_STOP) begin
          button_pending_next = 1'b1;
        end else begin
          valve_toggle_next = !valve_toggle;
          valve_drive_next  = !valve_toggle;
        end
      end
      default: begin
      end
    endcase

    // rearm; sticky command bit may rearm in the stopping step itself
    if (rearm_req && command_byte_next[REARM_BIT]) begin
      previous_sample_next = reported_count_next;
      batch_base_next      = reported_count_next;
      reported_count_next  = '0;
      flow_seen_next       = 1'b0;
      phase_next           = PH_WAIT;
      if (button_pending_next) begin
        button_pending_next = 1'b0;
        valve_toggle_next   = !valve_toggle_next;
        valve_drive_next    = valve_toggle_next;
      end
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      flow_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      flow_threshold <= cfg_wdata;
    end
  end

  // state update, one word per take
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      flow_seen       <= 1'b0;
      previous_sample <= '0;
      batch_base      <= '0;
      reported_count  <= '0;
      command_byte    <= CMD_RESET;
      valve_toggle    <= 1'b0;
      valve_drive     <= 1'b0;
      button_pending  <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      flow_seen       <= flow_seen_next;
      previous_sample <= previous_sample_next;
      batch_base      <= batch_base_next;
      reported_count  <= reported_count_next;
      command_byte    <= command_byte_next;
      valve_toggle    <= valve_toggle_next;
      valve_drive     <= valve_drive_next;
      button_pending  <= button_pending_next;
    end
  end

  // result reflects the state after this word
  always_comb begin
    result.phase          = phase_next;
    result.status_byte    = STATUS_ALWAYS | ((phase_next == PH_RUN) ? STATUS_RUN : 8'h00);
    result.measured_count = 32'(reported_count_next);
    result.valve_open     = valve_drive_next;
    result.flow_indicator = flow_seen_next;
  end

  `FBM_ASSERT_RST(a_stop_closed, clk, rst, (phase == PH_STOP) |-> !valve_drive, "valve open")
  `FBM_ASSERT_RST(a_pend_stop, clk, rst, (phase != PH_STOP) |-> !button_pending, "stray press")
  `FBM_ASSERT_RST(a_wait_zero, clk, rst, (phase == PH_WAIT) |-> (reported_count == '0), "count set")

endmodule

/* hdl/fbm_out_stage.sv */
// ----------------------------------------------------------------------------
// fbm_out_stage
// Result register with valid; refilled in the cycle the old word is taken.
// ----------------------------------------------------------------------------
module fbm_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  fbm_pkg::result_t load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fbm_pkg::result_t out_data
);
  import fbm_pkg::*;

  logic    out_valid_next;
  result_t data_q;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= load_data;
    end
  end

  assign out_data = data_q;

endmodule
